>>> src/mqwl_pkg.sv
// Shared types and constants for the message queue with wait lists.
// Used by every module of the block except the RAM; depends on nothing else.
package mqwl_pkg;

  // Default geometry handed down from the top level.
  localparam int unsigned QUEUE_DEPTH_DEF     = 16;
  localparam int unsigned MESSAGE_WIDTH_DEF   = 32;
  localparam int unsigned WAIT_LIST_DEPTH_DEF = 8;
  localparam int unsigned TASK_ID_WIDTH_DEF   = 4;

  // Configuration register: queue limit.
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] QUEUE_LIMIT_RESET = 5'd16;

  // Depth of the command queue between front and back.
  localparam int unsigned CQ_DEPTH = 2;

  // Item kind codes as they arrive on the input channel.
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_RECV   = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;
  localparam logic [1:0] KIND_FLUSH  = 2'd3;

  typedef enum logic [1:0] {
    OP_SEND,
    OP_RECV,
    OP_CANCEL,
    OP_FLUSH
  } op_e;

  typedef enum logic [1:0] {
    RES_DONE     = 2'd0,
    RES_NOSERVE  = 2'd1,
    RES_WAITING  = 2'd2,
    RES_OVERFLOW = 2'd3
  } status_e;

  // Which wait list an operation works on.
  typedef enum logic {
    LIST_RCV = 1'b0,
    LIST_SND = 1'b1
  } list_e;

  typedef enum logic {
    SQ_IDLE,
    SQ_RESP
  } seq_state_e;

  // Control part of a classified command.
  typedef struct packed {
    op_e  op;
    logic may_wait;
    logic cancel_snd;
  } cmd_ctl_t;

  // Control part of a result.
  typedef struct packed {
    status_e status;
    logic    woken_valid;
  } res_ctl_t;

endpackage

>>> src/message_queue_with_wait_lists_core.sv
// An item passes through the command queue; the back-end sequencer then executes
// it and takes the registered store read into the result register, and takes no
// new command until the result of the previous one has been loaded.
// A two-entry command queue and the result register let input and output stall
// independently. Reset clears pointers, counts and handshakes and sets the
// queue limit to 16; message store and wait list entries are not cleared.
module message_queue_with_wait_lists_core #(
  parameter int unsigned QUEUE_DEPTH     = mqwl_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MESSAGE_WIDTH   = mqwl_pkg::MESSAGE_WIDTH_DEF,
  parameter int unsigned WAIT_LIST_DEPTH = mqwl_pkg::WAIT_LIST_DEPTH_DEF,
  parameter int unsigned TASK_ID_WIDTH   = mqwl_pkg::TASK_ID_WIDTH_DEF,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned IN_BITS    = MESSAGE_WIDTH + TASK_ID_WIDTH + 2,
  localparam int unsigned IN_DATA_W  = ((IN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_BITS   = MESSAGE_WIDTH + 1 + TASK_ID_WIDTH + CNT_W,
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration: queue limit.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [mqwl_pkg::CFG_W-1:0] cfg_data_i,
  // Input items.
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata: message_in, task_id, may_wait, cancel_sender_list, zero fill
  input  logic [IN_DATA_W-1:0]       s_axis_tdata_i,
  // tuser: kind
  input  logic [1:0]                 s_axis_tuser_i,
  // Result items.
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // tdata: message_out, woken_valid, woken_task, messages_waiting, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // tuser: status
  output logic [1:0]                 m_axis_tuser_o
);

  import mqwl_pkg::*;

  logic [CFG_W-1:0]         queue_limit_q;
  logic                     cmd_valid, cmd_ready;
  cmd_ctl_t                 cmd_ctl;
  logic [MESSAGE_WIDTH-1:0] cmd_msg;
  logic [TASK_ID_WIDTH-1:0] cmd_tid;
  res_ctl_t                 res_ctl;
  logic [MESSAGE_WIDTH-1:0] res_msg;
  logic [TASK_ID_WIDTH-1:0] res_task;
  logic [CNT_W-1:0]         res_count;

  // Queue limit register; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_limit_q <= QUEUE_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      queue_limit_q <= cfg_data_i;
    end
  end

  mqwl_front #(
    .MESSAGE_WIDTH (MESSAGE_WIDTH),
    .TASK_ID_WIDTH (TASK_ID_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .kind_i       (s_axis_tuser_i),
    .msg_i        (s_axis_tdata_i[MESSAGE_WIDTH-1:0]),
    .tid_i        (s_axis_tdata_i[MESSAGE_WIDTH +: TASK_ID_WIDTH]),
    .may_wait_i   (s_axis_tdata_i[MESSAGE_WIDTH + TASK_ID_WIDTH]),
    .cancel_snd_i (s_axis_tdata_i[MESSAGE_WIDTH + TASK_ID_WIDTH + 1]),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_ctl_o    (cmd_ctl),
    .cmd_msg_o    (cmd_msg),
    .cmd_tid_o    (cmd_tid)
  );

  mqwl_back #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .MESSAGE_WIDTH   (MESSAGE_WIDTH),
    .WAIT_LIST_DEPTH (WAIT_LIST_DEPTH),
    .TASK_ID_WIDTH   (TASK_ID_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_limit_i (queue_limit_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_ctl_i     (cmd_ctl),
    .cmd_msg_i     (cmd_msg),
    .cmd_tid_i     (cmd_tid),
    .res_valid_o   (m_axis_tvalid_o),
    .res_ready_i   (m_axis_tready_i),
    .res_ctl_o     (res_ctl),
    .res_msg_o     (res_msg),
    .res_task_o    (res_task),
    .res_count_o   (res_count)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata_o = OUT_DATA_W'({res_count, res_task, res_ctl.woken_valid, res_msg});
  assign m_axis_tuser_o = res_ctl.status;

endmodule

>>> src/mqwl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the message store; depends on nothing else.
module mqwl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/mqwl_front.sv
// Front end: accepts items, decodes the kind into an operation and buffers
// commands in a short queue for the back end. Depends on mqwl_pkg.
module mqwl_front #(
  parameter int unsigned MESSAGE_WIDTH = mqwl_pkg::MESSAGE_WIDTH_DEF,
  parameter int unsigned TASK_ID_WIDTH = mqwl_pkg::TASK_ID_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               kind_i,
  input  logic [MESSAGE_WIDTH-1:0] msg_i,
  input  logic [TASK_ID_WIDTH-1:0] tid_i,
  input  logic                     may_wait_i,
  input  logic                     cancel_snd_i,
  output logic                     cmd_valid_o,
  input  logic                     cmd_ready_i,
  output mqwl_pkg::cmd_ctl_t       cmd_ctl_o,
  output logic [MESSAGE_WIDTH-1:0] cmd_msg_o,
  output logic [TASK_ID_WIDTH-1:0] cmd_tid_o
);

  import mqwl_pkg::*;

  localparam int unsigned PTR_W = $clog2(CQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(CQ_DEPTH + 1);

  cmd_ctl_t                 ctl_q [CQ_DEPTH];
  logic [MESSAGE_WIDTH-1:0] msg_q [CQ_DEPTH];
  logic [TASK_ID_WIDTH-1:0] tid_q [CQ_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     push, pop;
  cmd_ctl_t                 in_ctl;

  // Decode the item kind into an operation.
  always_comb begin
    in_ctl.may_wait   = may_wait_i;
    in_ctl.cancel_snd = cancel_snd_i;
    unique case (kind_i)
      KIND_SEND:   in_ctl.op = OP_SEND;
      KIND_RECV:   in_ctl.op = OP_RECV;
      KIND_CANCEL: in_ctl.op = OP_CANCEL;
      KIND_FLUSH:  in_ctl.op = OP_FLUSH;
      default:     in_ctl.op = OP_FLUSH;
    endcase
  end

  assign in_ready_o  = (cnt_q != CNT_W'(CQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  assign cmd_ctl_o = ctl_q[rd_ptr_q];
  assign cmd_msg_o = msg_q[rd_ptr_q];
  assign cmd_tid_o = tid_q[rd_ptr_q];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = PTR_W'(wr_ptr_q + PTR_W'(1));
    end
    if (pop) begin
      rd_ptr_d = PTR_W'(rd_ptr_q + PTR_W'(1));
    end
    if (push && !pop) begin
      cnt_d = CNT_W'(cnt_q + CNT_W'(1));
    end else if (pop && !push) begin
      cnt_d = CNT_W'(cnt_q - CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue entries carry no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_q[wr_ptr_q] <= in_ctl;
      msg_q[wr_ptr_q] <= msg_i;
      tid_q[wr_ptr_q] <= tid_i;
    end
  end

endmodule

>>> src/mqwl_back.sv
// Back end: executes commands against the message store and the two wait
// lists, and holds the result register. Depends on mqwl_pkg and mqwl_ram.
module mqwl_back #(
  parameter int unsigned QUEUE_DEPTH     = mqwl_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MESSAGE_WIDTH   = mqwl_pkg::MESSAGE_WIDTH_DEF,
  parameter int unsigned WAIT_LIST_DEPTH = mqwl_pkg::WAIT_LIST_DEPTH_DEF,
  parameter int unsigned TASK_ID_WIDTH   = mqwl_pkg::TASK_ID_WIDTH_DEF,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mqwl_pkg::CFG_W-1:0] queue_limit_i,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  mqwl_pkg::cmd_ctl_t         cmd_ctl_i,
  input  logic [MESSAGE_WIDTH-1:0]   cmd_msg_i,
  input  logic [TASK_ID_WIDTH-1:0]   cmd_tid_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output mqwl_pkg::res_ctl_t         res_ctl_o,
  output logic [MESSAGE_WIDTH-1:0]   res_msg_o,
  output logic [TASK_ID_WIDTH-1:0]   res_task_o,
  output logic [CNT_W-1:0]           res_count_o
);

  import mqwl_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned WLC_W  = $clog2(WAIT_LIST_DEPTH + 1);
  localparam int unsigned WLI_W  = (WAIT_LIST_DEPTH > 1) ? $clog2(WAIT_LIST_DEPTH) : 1;
  localparam int unsigned LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned NLISTS = 2;

  seq_state_e state_q, state_d;

  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] lim, wp_inc, rp_inc;
  logic [LIM_W-1:0] lim_ext;
  logic             full, empty;

  logic [TASK_ID_WIDTH-1:0] ids_q [NLISTS][WAIT_LIST_DEPTH];
  logic [TASK_ID_WIDTH-1:0] ids_d [NLISTS][WAIT_LIST_DEPTH];
  logic [WLC_W-1:0]         n_q [NLISTS];
  logic [WLC_W-1:0]         n_d [NLISTS];
  logic [WAIT_LIST_DEPTH-1:0] hit [NLISTS];
  logic [WLI_W-1:0]         hit_pos [NLISTS];
  logic [WLI_W-1:0]         top_idx [NLISTS];

  status_e                  pend_status_q, pend_status_d;
  logic                     pend_woken_q, pend_woken_d;
  logic [TASK_ID_WIDTH-1:0] pend_task_q, pend_task_d;
  logic                     pend_rd_q, pend_rd_d;

  logic                     out_valid_q, out_valid_d;
  res_ctl_t                 out_ctl_q, out_ctl_d;
  logic [MESSAGE_WIDTH-1:0] out_msg_q, out_msg_d;
  logic [TASK_ID_WIDTH-1:0] out_task_q, out_task_d;
  logic [CNT_W-1:0]         out_cnt_q, out_cnt_d;

  logic                     exec_en, resp_load;
  logic                     ram_we, ram_re;
  logic [MESSAGE_WIDTH-1:0] ram_rdata;
  logic                     do_pop, do_push;
  list_e                    pop_l, push_l, cancel_l;

  // Effective limit: zero acts as one, large values clip to the depth.
  always_comb begin
    lim_ext = LIM_W'(queue_limit_i);
    if (lim_ext == '0) begin
      lim = CNT_W'(1);
    end else if (lim_ext > LIM_W'(QUEUE_DEPTH)) begin
      lim = CNT_W'(QUEUE_DEPTH);
    end else begin
      lim = CNT_W'(lim_ext);
    end
  end

  assign full   = (cnt_q >= lim);
  assign empty  = (cnt_q == '0);
  assign wp_inc = CNT_W'(CNT_W'(wp_q) + CNT_W'(1));
  assign rp_inc = CNT_W'(CNT_W'(rp_q) + CNT_W'(1));

  // Per-entry task match on both lists, lowest matching position and top.
  always_comb begin
    for (int l = 0; l < NLISTS; l++) begin
      hit_pos[l] = '0;
      for (int i = 0; i < WAIT_LIST_DEPTH; i++) begin
        hit[l][i] = (WLC_W'(i) < n_q[l]) && (ids_q[l][i] == cmd_tid_i);
      end
      for (int i = WAIT_LIST_DEPTH - 1; i >= 0; i--) begin
        if (hit[l][i]) begin
          hit_pos[l] = WLI_W'(i);
        end
      end
      top_idx[l] = WLI_W'(n_q[l] - WLC_W'(1));
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE: if (cmd_valid_i) state_d = SQ_RESP;
      SQ_RESP: if (!out_valid_q || res_ready_i) state_d = SQ_IDLE;
      default: state_d = SQ_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    cmd_ready_o = 1'b0;
    resp_load   = 1'b0;
    unique case (state_q)
      SQ_IDLE: cmd_ready_o = 1'b1;
      SQ_RESP: resp_load   = !out_valid_q || res_ready_i;
      default: cmd_ready_o = 1'b0;
    endcase
  end

  assign exec_en = cmd_valid_i && cmd_ready_o;

  // Command execution: store pointers, wait lists and pending result.
  always_comb begin
    wp_d          = wp_q;
    rp_d          = rp_q;
    cnt_d         = cnt_q;
    ids_d         = ids_q;
    n_d           = n_q;
    pend_status_d = pend_status_q;
    pend_woken_d  = pend_woken_q;
    pend_task_d   = pend_task_q;
    pend_rd_d     = pend_rd_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    do_pop        = 1'b0;
    do_push       = 1'b0;
    pop_l         = LIST_RCV;
    push_l        = LIST_RCV;
    cancel_l      = cmd_ctl_i.cancel_snd ? LIST_SND : LIST_RCV;

    if (exec_en) begin
      pend_status_d = RES_DONE;
      pend_woken_d  = 1'b0;
      pend_task_d   = '0;
      pend_rd_d     = 1'b0;
      unique case (cmd_ctl_i.op)
        OP_SEND: begin
          if (!full) begin
            ram_we = 1'b1;
            wp_d   = (wp_inc >= lim) ? '0 : PTR_W'(wp_inc);
            cnt_d  = CNT_W'(cnt_q + CNT_W'(1));
            do_pop = 1'b1;
            pop_l  = LIST_RCV;
          end else if (cmd_ctl_i.may_wait) begin
            do_push = 1'b1;
            push_l  = LIST_SND;
          end else begin
            pend_status_d = RES_NOSERVE;
          end
        end
        OP_RECV: begin
          if (!empty) begin
            ram_re    = 1'b1;
            pend_rd_d = 1'b1;
            rp_d      = (rp_inc >= lim) ? '0 : PTR_W'(rp_inc);
            cnt_d     = CNT_W'(cnt_q - CNT_W'(1));
            do_pop    = 1'b1;
            pop_l     = LIST_SND;
          end else if (cmd_ctl_i.may_wait) begin
            do_push = 1'b1;
            push_l  = LIST_RCV;
          end else begin
            pend_status_d = RES_NOSERVE;
          end
        end
        OP_CANCEL: begin
          if (|hit[cancel_l]) begin
            // Close the gap left by the removed entry.
            for (int j = 0; j < WAIT_LIST_DEPTH - 1; j++) begin
              if (WLI_W'(j) >= hit_pos[cancel_l]) begin
                ids_d[cancel_l][j] = ids_q[cancel_l][j+1];
              end
            end
            n_d[cancel_l] = WLC_W'(n_q[cancel_l] - WLC_W'(1));
            pend_woken_d  = 1'b1;
            pend_task_d   = cmd_tid_i;
          end else begin
            pend_status_d = RES_NOSERVE;
          end
        end
        OP_FLUSH: begin
          wp_d  = '0;
          rp_d  = '0;
          cnt_d = '0;
        end
        default: pend_status_d = RES_DONE;
      endcase

      // Release the newest waiter on the opposite list.
      if (do_pop && (n_q[pop_l] != '0)) begin
        pend_woken_d = 1'b1;
        pend_task_d  = ids_q[pop_l][top_idx[pop_l]];
        n_d[pop_l]   = WLC_W'(n_q[pop_l] - WLC_W'(1));
      end

      // Join a wait list once; a full list reports overflow.
      if (do_push) begin
        if (|hit[push_l]) begin
          pend_status_d = RES_WAITING;
        end else if (n_q[push_l] >= WLC_W'(WAIT_LIST_DEPTH)) begin
          pend_status_d = RES_OVERFLOW;
        end else begin
          ids_d[push_l][n_q[push_l][WLI_W-1:0]] = cmd_tid_i;
          n_d[push_l]   = WLC_W'(n_q[push_l] + WLC_W'(1));
          pend_status_d = RES_WAITING;
        end
      end
    end
  end

  // Result register, loaded once the store read data is available.
  always_comb begin
    out_valid_d = out_valid_q;
    out_ctl_d   = out_ctl_q;
    out_msg_d   = out_msg_q;
    out_task_d  = out_task_q;
    out_cnt_d   = out_cnt_q;
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (resp_load) begin
      out_valid_d           = 1'b1;
      out_ctl_d.status      = pend_status_q;
      out_ctl_d.woken_valid = pend_woken_q;
      out_msg_d             = pend_rd_q ? ram_rdata : '0;
      out_task_d            = pend_task_q;
      out_cnt_d             = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < NLISTS; l++) begin
        n_q[l] <= '0;
      end
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
    end
  end

  // Wait list entries and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    ids_q         <= ids_d;
    pend_status_q <= pend_status_d;
    pend_woken_q  <= pend_woken_d;
    pend_task_q   <= pend_task_d;
    pend_rd_q     <= pend_rd_d;
    out_ctl_q     <= out_ctl_d;
    out_msg_q     <= out_msg_d;
    out_task_q    <= out_task_d;
    out_cnt_q     <= out_cnt_d;
  end

  // Message store.
  mqwl_ram #(
    .WIDTH (MESSAGE_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (cmd_msg_i),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o = out_valid_q;
  assign res_ctl_o   = out_ctl_q;
  assign res_msg_o   = out_msg_q;
  assign res_task_o  = out_task_q;
  assign res_count_o = out_cnt_q;

endmodule

>>> src/mqwl_checker.sv
// Checks on the result channel of the message queue over time, and the bind
// that attaches them to the top level. Depends on mqwl_pkg.
module mqwl_checker #(
  parameter int unsigned QUEUE_DEPTH   = mqwl_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned MESSAGE_WIDTH = mqwl_pkg::MESSAGE_WIDTH_DEF,
  parameter int unsigned TASK_ID_WIDTH = mqwl_pkg::TASK_ID_WIDTH_DEF,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_BITS   = MESSAGE_WIDTH + 1 + TASK_ID_WIDTH + CNT_W,
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_i,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input logic [1:0]            m_axis_tuser_i
);

  import mqwl_pkg::*;

  localparam int unsigned WV_POS   = MESSAGE_WIDTH;
  localparam int unsigned TASK_POS = MESSAGE_WIDTH + 1;
  localparam int unsigned CNT_POS  = MESSAGE_WIDTH + 1 + TASK_ID_WIDTH;

  logic                     woken;
  logic [TASK_ID_WIDTH-1:0] task_f;
  logic [MESSAGE_WIDTH-1:0] msg_f;
  logic [CNT_W-1:0]         cnt_f;

  assign woken  = m_axis_tdata_i[WV_POS];
  assign task_f = m_axis_tdata_i[TASK_POS +: TASK_ID_WIDTH];
  assign msg_f  = m_axis_tdata_i[MESSAGE_WIDTH-1:0];
  assign cnt_f  = m_axis_tdata_i[CNT_POS +: CNT_W];

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("result changed while stalled");

  // A released task only comes with a completed operation.
  a_woken_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && woken |-> m_axis_tuser_i == RES_DONE)
    else $error("task released on a failed operation");

  // Without a release the task field reads zero.
  a_task_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !woken |-> task_f == '0)
    else $error("task field set without a release");

  // A message is only delivered by a successful receive.
  a_msg_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (msg_f != '0) |-> m_axis_tuser_i == RES_DONE)
    else $error("message delivered on a failed operation");

  // The stored count never exceeds the store depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> cnt_f <= CNT_W'(QUEUE_DEPTH))
    else $error("message count beyond the store depth");

endmodule

bind message_queue_with_wait_lists_core mqwl_checker #(
  .QUEUE_DEPTH   (QUEUE_DEPTH),
  .MESSAGE_WIDTH (MESSAGE_WIDTH),
  .TASK_ID_WIDTH (TASK_ID_WIDTH)
) u_mqwl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);
